FILE: design/tksi_pkg.sv
// Shared types, constants and name-cleanup function for the top-k sorted insert core.
// No dependencies; imported by tksi_cell and top_k_sorted_insert_core.
`default_nettype none

package tksi_pkg;

  // Default configuration
  localparam int ENTRIES_DEF    = 30;
  localparam int NAME_CHARS_DEF = 8;

  // Field widths
  localparam int SCORE_W = 32;
  localparam int NAME_W  = 64;
  localparam int RANK_W  = 5;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 8;

  // Reset name "Free", first character in the low byte
  localparam logic [NAME_W-1:0] FREE_NAME = 64'h0000_0000_6565_7246;
  localparam logic [7:0]        SPACE_CHAR = 8'h20;

  // One table entry
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [NAME_W-1:0]         name;
  } entry_t;

  // Keep only the low nchars bytes
  function automatic logic [NAME_W-1:0] limit_name(input logic [NAME_W-1:0] v,
                                                   input int nchars);
    logic [NAME_W-1:0] res;
    int i;
    res = '0;
    for (i = 0; i < 8; i++) begin
      if (i < nchars) res[8*i +: 8] = v[8*i +: 8];
    end
    return res;
  endfunction

  // Cut at the first zero byte, then turn trailing spaces into zeros
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw,
                                                   input int nchars);
    logic [7:0]        in_name;
    logic [7:0]        live;
    logic [NAME_W-1:0] res;
    logic              run;
    logic              tail;
    int i;
    run  = 1'b1;
    tail = 1'b0;
    res  = '0;
    for (i = 0; i < 8; i++) begin
      run        = run && (i < nchars) && (raw[8*i +: 8] != 8'h00);
      in_name[i] = run;
      live[i]    = run && (raw[8*i +: 8] != SPACE_CHAR);
    end
    for (i = 7; i >= 0; i--) begin
      tail = tail | live[i];
      if (in_name[i] && tail) res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/tksi_cell.sv
// One slot of the sorted table: holds a score/name pair and compares it with the offered score.
// Depends on tksi_pkg.
`default_nettype none

module tksi_cell
  import tksi_pkg::*;
#(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      upd,        // beat accepted this cycle
  input  wire entry_t                    new_entry,  // offered pair, name cleaned
  input  wire logic                      prev_lower, // left neighbor is below offer
  input  wire entry_t                    prev_entry, // left neighbor's pair
  output      logic                      lower,      // this slot is below offer
  output      entry_t                    entry
);

  entry_t entry_r, entry_nxt;

  // Strictly lower stored score lets the offer in
  assign lower = (entry_r.score < new_entry.score);
  assign entry = entry_r;

  // Insert here, shift from the left, or hold
  always_comb begin
    entry_nxt = entry_r;
    if (upd) begin
      if (prev_lower) begin
        entry_nxt = prev_entry;
      end else if (lower) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.score <= '0;
      entry_r.name  <= limit_name(FREE_NAME, NAME_CHARS);
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/top_k_sorted_insert_core.sv
// Top level of the top-k sorted insert core: stream ports, chain of table cells, rank encoder.
// Depends on tksi_pkg and tksi_cell.
`default_nettype none

// Channel | Direction | tdata fields (low bit up)                  | tuser/tlast
// in_     | slave     | new_score[31:0], name_chars[95:32]         | none
// out_    | master    | inserted[0], rank[5:1], zero pad [7:6]     | none
//
// For each accepted beat, every cell compares its score with the
// offer in parallel and shifts or loads at the same edge, while the rank is
// encoded from the cell flags into the output register. One beat per cycle
// is sustained; in_tready drops only while a result waits and out_tready is low.
// Synchronous active-low reset loads score 0 and name "Free" in every cell.

module top_k_sorted_insert_core
  import tksi_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // new_score[31:0], name_chars[95:32]
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata   // inserted[0], rank[5:1], zeros
);

  logic               accept;
  entry_t             new_entry;
  entry_t             cells [ENTRIES];
  logic [ENTRIES-1:0] lower;
  logic [ENTRIES-1:0] first;
  logic               hit;
  logic [RANK_W-1:0]  rank;

  logic              out_valid_r, out_valid_nxt;
  logic              inserted_r;
  logic [RANK_W-1:0] rank_r;

  // Handshake: take a beat unless a result is stuck
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Offered pair
  assign new_entry.score = in_tdata[SCORE_W-1:0];
  assign new_entry.name  = clean_name(in_tdata[SCORE_W +: NAME_W], NAME_CHARS);

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        tksi_cell #(.NAME_CHARS(NAME_CHARS)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .upd       (accept),
          .new_entry (new_entry),
          .prev_lower(1'b0),
          .prev_entry(new_entry),
          .lower     (lower[g]),
          .entry     (cells[g])
        );
        assign first[g] = lower[g];
      end else begin : g_body
        tksi_cell #(.NAME_CHARS(NAME_CHARS)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .upd       (accept),
          .new_entry (new_entry),
          .prev_lower(lower[g-1]),
          .prev_entry(cells[g-1]),
          .lower     (lower[g]),
          .entry     (cells[g])
        );
        assign first[g] = lower[g] && !lower[g-1];
      end
    end
  endgenerate

  // Rank of the single insertion point, low bits only
  always_comb begin
    rank = '0;
    for (int n = 0; n < ENTRIES; n++) begin
      for (int b = 0; b < RANK_W; b++) begin
        if (first[n] && (((n >> b) & 1) == 1)) rank[b] = 1'b1;
      end
    end
  end
  assign hit = |lower;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inserted_r <= hit;
      rank_r     <= rank;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RANK_W-1){1'b0}}, rank_r, inserted_r};

endmodule

`default_nettype wire

FILE: tb/sv/tb_top_k_sorted_insert_core.sv
// Testbench for top_k_sorted_insert_core: directed and random offers against a local top-k table.
// Depends on tksi_pkg and top_k_sorted_insert_core; checks inserted/rank of every result beat.
`timescale 1ns / 1ps

module tb_top_k_sorted_insert_core;
  import tksi_pkg::*;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int NUM_CHARS   = NAME_CHARS_DEF;
  localparam int RANDOM_OFFERS = 1750;
  localparam int CYCLE_LIMIT   = 100000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              inserted;
    logic [RANK_W-1:0] rank;
  } outcome_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // new_score[31:0], name_chars[95:32]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // inserted[0], rank[5:1], zeros

  // Local copy of the leaderboard
  logic signed [SCORE_W-1:0] score_tbl [NUM_ENTRIES];
  logic [NAME_W-1:0]         name_tbl  [NUM_ENTRIES];

  outcome_t pending_results[$];
  int       err_count;
  int       result_count;
  int       insert_count;
  logic [31:0] ranks_hit;
  int       in_idle_pct;
  int       out_stall_pct;
  int       cycle_count;

  top_k_sorted_insert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock, 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 20)
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Stored name: cut at first zero byte (within NUM_CHARS), then drop trailing spaces
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    int len;
    int k;
    len = 0;
    res = '0;
    while (len < NUM_CHARS && raw[8*len +: 8] != 8'h00) len++;
    while (len > 0 && raw[8*(len-1) +: 8] == SPACE_CHAR) len--;
    for (k = 0; k < len; k++) res[8*k +: 8] = raw[8*k +: 8];
    return res;
  endfunction

  // Sorted insert: first slot with a strictly lower score takes the offer
  function automatic void predict_insert(input logic signed [SCORE_W-1:0] score,
                                         input logic [NAME_W-1:0] name,
                                         output outcome_t res);
    int n;
    int slot;
    slot = -1;
    res  = '0;
    for (n = 0; n < NUM_ENTRIES; n++)
      if (slot < 0 && score_tbl[n] < score) slot = n;
    if (slot >= 0) begin
      for (n = NUM_ENTRIES - 1; n > slot; n--) begin
        score_tbl[n] = score_tbl[n-1];
        name_tbl[n]  = name_tbl[n-1];
      end
      score_tbl[slot] = score;
      name_tbl[slot]  = trim_name(name);
      res.inserted = 1'b1;
      res.rank     = slot[RANK_W-1:0];
    end
  endfunction

  // Send one offer beat; the prediction is made at the accepting edge
  task automatic offer_entry(input logic signed [SCORE_W-1:0] score,
                             input logic [NAME_W-1:0] name);
    outcome_t res;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {name, score};
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_insert(score, name, res);
    pending_results.push_back(res);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        result_count++;
        if (out_tdata[0] !== want.inserted)
          report_mismatch("inserted", out_tdata[0], want.inserted);
        if (out_tdata[5:1] !== want.rank)
          report_mismatch("rank", out_tdata[5:1], want.rank);
        if (want.inserted) begin
          insert_count++;
          ranks_hit[want.rank] = 1'b1;
        end
      end
    end
  end

  // Random name: either raw bits or printable text with trailing spaces
  function automatic logic [NAME_W-1:0] rand_name();
    logic [NAME_W-1:0] v;
    int len;
    int pad;
    int k;
    v = '0;
    if ($urandom_range(3) == 0) begin
      v = {$urandom, $urandom};
    end else begin
      len = $urandom_range(8);
      pad = $urandom_range(8 - len);
      for (k = 0; k < len; k++)
        v[8*k +: 8] = ($urandom_range(5) == 0) ? SPACE_CHAR : 8'($urandom_range(8'h21, 8'h7e));
      for (k = len; k < len + pad; k++) v[8*k +: 8] = SPACE_CHAR;
    end
    return v;
  endfunction

  // Random score: mostly close to a stored score, so every rank and tie shows up
  function automatic logic signed [SCORE_W-1:0] rand_score();
    longint t;
    int pick;
    pick = $urandom_range(199);
    if (pick == 0) return SCORE_MAX;
    if (pick == 1) return SCORE_MIN;
    if (pick < 30) return $urandom;
    t = longint'(score_tbl[$urandom_range(NUM_ENTRIES - 1)]) + $urandom_range(4) - 2;
    if (t > longint'(SCORE_MAX)) t = SCORE_MAX;
    if (t < longint'(SCORE_MIN)) t = SCORE_MIN;
    return t[SCORE_W-1:0];
  endfunction

  // Fresh table holds zeros: ties and lower scores are rejected, then two equal higher scores go in
  task automatic test_fresh_table_ties();
    offer_entry(32'sd0, 64'h0000_0000_6565_7246);
    offer_entry(-32'sd1, 64'h0000_0000_0000_0041);
    offer_entry(SCORE_MIN, 64'h0000_0000_0000_0000);
    offer_entry(32'sd1, 64'h0000_0000_0000_0042);
    offer_entry(32'sd1, 64'h0000_0000_0000_0043);  // tie goes below
  endtask

  // Name cleanup paths: all ones, trailing spaces, all spaces, empty, zero in the middle, spaces between characters
  task automatic test_name_cleanup();
    offer_entry(SCORE_MAX, 64'hffff_ffff_ffff_ffff);
    offer_entry(32'sd5, 64'h0000_0000_2020_6261);
    offer_entry(32'sd3, 64'h2020_2020_2020_2020);
    offer_entry(32'sd3, 64'h0000_0000_0000_0000);
    offer_entry(32'sd4, 64'h0000_0000_0062_0061);
    offer_entry(32'sd4, 64'h2061_2062_2063_2064);
  endtask

  // Ordering: tie at the top, offers near the bottom end and sign extremes
  task automatic test_rank_order();
    offer_entry(SCORE_MAX, 64'h4142_4344_4546_4748);
    offer_entry(32'sd2, 64'h0000_0000_0000_2078);
    offer_entry(-32'sd2147483647, 64'h0000_0000_0000_0079);
    offer_entry(32'sh4000_0000, 64'h0000_0000_0000_007a);
    offer_entry(32'sh8000_0001, 64'h0000_0000_0000_0020);
  endtask

  // Random offers with idle and stall phases, one long stretch at full rate
  task automatic test_random_offers();
    int k;
    for (k = 0; k < RANDOM_OFFERS; k++) begin
      if (k == 600) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      if (k == 1000) begin
        in_idle_pct   = 30;
        out_stall_pct = 30;
      end
      if (k == 1300) out_stall_pct = 60;
      if (k == 1500) out_stall_pct = 30;
      offer_entry(rand_score(), rand_name());
    end
  endtask

  initial begin
    int n;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    err_count     = 0;
    result_count  = 0;
    insert_count  = 0;
    ranks_hit     = '0;
    cycle_count   = 0;
    in_idle_pct   = 30;
    out_stall_pct = 30;
    for (n = 0; n < NUM_ENTRIES; n++) begin
      score_tbl[n] = '0;
      name_tbl[n]  = FREE_NAME;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_fresh_table_ties();
    test_name_cleanup();
    test_rank_order();
    test_random_offers();

    @(negedge clk);
    in_tvalid <= 1'b0;
    // Drain the remaining result beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d results: %0d inserted, %0d rejected; %0d of %0d ranks taken",
             result_count, insert_count, result_count - insert_count,
             $countones(ranks_hit), NUM_ENTRIES);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
